### hw/rtl/ita_pkg.sv
// Shared types, constants and helpers of the integer to ASCII formatter.
`default_nettype none

package ita_pkg;

   // Fixed field widths of the channels
   localparam int VALUE_W   = 64;
   localparam int MODE_W    = 2;
   localparam int PAD_BITS  = 6;
   localparam int CHAR_W    = 8;
   localparam int DIGIT_W   = 4;

   // Parameter defaults for the top level
   localparam int DEF_VALUE_BITS  = 64;
   localparam int DEF_DIGIT_STORE = 32;
   localparam int DEF_MAX_PAD     = 40;

   // Quotient bits resolved per cycle by the decimal divider
   localparam int DEC_STEP_BITS = 8;

   // ASCII codes
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;

   typedef enum logic [MODE_W-1:0] {
      RADIX_DEC = 2'd0,
      RADIX_OCT = 2'd1,
      RADIX_HEX = 2'd2
   } radix_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SETTLE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic      start;
      radix_type radix;
   } div_ctrl_type;

   typedef struct packed {
      logic               done;
      logic [DIGIT_W-1:0] digit;
   } div_stat_type;

   // Map a digit value to its lowercase ASCII character
   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] ch;
      if (d < DIGIT_W'(10)) begin
         ch = CHAR_ZERO + CHAR_W'(d);
      end else begin
         ch = CHAR_LOW_A + CHAR_W'(d) - CHAR_W'(10);
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/ita_if.sv
// Request and response channel interfaces of the integer to ASCII formatter.
`default_nettype none

interface ita_req_if import ita_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  value;
   logic [MODE_W-1:0]   mode;
   logic                signed_value;
   logic                show_prefix;
   logic                zero_pad;
   logic [PAD_BITS-1:0] pad_width;

   modport source (
      output valid, value, mode, signed_value, show_prefix, zero_pad, pad_width,
      input  ready
   );
   modport sink (
      input  valid, value, mode, signed_value, show_prefix, zero_pad, pad_width,
      output ready
   );
endinterface

interface ita_rsp_if import ita_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] character;
   logic              last;

   modport source (
      output valid, character, last,
      input  ready
   );
   modport sink (
      input  valid, character, last,
      output ready
   );
endinterface

`default_nettype wire

### hw/rtl/ita_div_unit.sv
// Iterative divider by the radix: yields one digit and the quotient per run.
`default_nettype none

module ita_div_unit import ita_pkg::*; #(
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire div_ctrl_type          ctrl,
   input  wire logic [VALUE_BITS-1:0] operand,
   output      div_stat_type          stat,
   output      logic [VALUE_BITS-1:0] quotient
);

   localparam int CHUNKS = (VALUE_BITS + DEC_STEP_BITS - 1) / DEC_STEP_BITS;
   localparam int WORK_W = CHUNKS * DEC_STEP_BITS;
   localparam int CNT_W  = $clog2(CHUNKS + 1);

   logic [WORK_W-1:0]        work_ff, work_in;
   logic [DIGIT_W-1:0]       rem_ff, rem_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   radix_type                radix_ff, radix_in;

   always_comb begin
      logic [DIGIT_W-1:0]       r;
      logic [DIGIT_W:0]         t;
      logic [DEC_STEP_BITS-1:0] qbits;
      work_in  = work_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      radix_in = radix_ff;
      r        = rem_ff;
      t        = '0;
      qbits    = '0;
      if (ctrl.start) begin
         work_in  = WORK_W'(operand);
         rem_in   = '0;
         cnt_in   = CNT_W'(CHUNKS);
         busy_in  = 1'b1;
         radix_in = ctrl.radix;
      end else if (busy_ff) begin
         case (radix_ff)
            RADIX_DEC: begin
               // restoring division by ten over one chunk, top bit first
               for (int i = 0; i < DEC_STEP_BITS; i++) begin
                  t = {r, work_ff[WORK_W-1-i]};
                  qbits[DEC_STEP_BITS-1-i] = (t >= (DIGIT_W+1)'(10));
                  if (t >= (DIGIT_W+1)'(10)) begin
                     r = DIGIT_W'(t - (DIGIT_W+1)'(10));
                  end else begin
                     r = t[DIGIT_W-1:0];
                  end
               end
               work_in = (work_ff << DEC_STEP_BITS) | WORK_W'(qbits);
               rem_in  = r;
               cnt_in  = cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
            RADIX_OCT: begin
               rem_in  = {1'b0, work_ff[2:0]};
               work_in = work_ff >> 3;
               busy_in = 1'b0;
               done_in = 1'b1;
            end
            default: begin
               rem_in  = work_ff[DIGIT_W-1:0];
               work_in = work_ff >> DIGIT_W;
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      work_ff  <= work_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      radix_ff <= radix_in;
   end

   assign stat.done  = done_ff;
   assign stat.digit = rem_ff;
   assign quotient   = work_ff[VALUE_BITS-1:0];

endmodule

`default_nettype wire

### hw/rtl/integer_to_ascii_formatter_unit.sv
// Top level of the integer to ASCII formatter: sequencer, digit store and output stage.
`default_nettype none

// Channel   Dir  Payload                                           Handshake
// req_ch    in   value, mode, signed_value, show_prefix,          valid / ready
//                zero_pad, pad_width
// rsp_ch    out  character, last                                  valid / ready
//
// Digits: decimal digits come from the shared divider, which resolves 8 quotient bits a
// cycle over CHUNKS = ceil(VALUE_BITS/8) chunks (8 at 64 bits); octal and hex digits are
// shifted out of the low bits by the same divider. The settle state follows, then one
// character a cycle while rsp_ch is ready. req_ch is ready only between transactions.
// Reset clears the sequencer, divider control and output valid; the digit store
// needs no clearing since only digits of the current transaction are read.
// A stall on rsp_ch holds the current character and freezes emission.

module integer_to_ascii_formatter_unit import ita_pkg::*; #(
   parameter int VALUE_BITS  = DEF_VALUE_BITS,
   parameter int DIGIT_STORE = DEF_DIGIT_STORE,
   parameter int MAX_PAD     = DEF_MAX_PAD
) (
   input wire logic clock,
   input wire logic reset,
   ita_req_if.sink   req_ch,
   ita_rsp_if.source rsp_ch
);

   localparam int AW    = $clog2(DIGIT_STORE);
   localparam int LEN_W = $clog2(DIGIT_STORE + 1);
   localparam int CMP_W = (LEN_W > PAD_BITS) ? LEN_W : PAD_BITS;

   state_type             state_ff, state_in;
   radix_type             radix_ff, radix_in;
   logic                  sign_ff, sign_in;
   logic [1:0]            prefix_cnt_ff, prefix_cnt_in;
   logic                  zpad_ff, zpad_in;
   logic [PAD_BITS-1:0]   width_ff, width_in;
   logic [PAD_BITS-1:0]   pad_cnt_ff, pad_cnt_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [AW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [DIGIT_W-1:0]    rd_data_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]     rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [DIGIT_W-1:0]    digit_mem [DIGIT_STORE];

   div_ctrl_type          div_ctrl;
   div_stat_type          div_stat;
   logic [VALUE_BITS-1:0] div_operand;
   logic [VALUE_BITS-1:0] div_quotient;

   radix_type             radix_sel;
   logic [VALUE_BITS-1:0] raw_value;
   logic                  is_neg;
   logic [VALUE_BITS-1:0] magnitude;
   logic [PAD_BITS-1:0]   width_sat;
   logic                  req_fire;
   logic                  out_free;
   logic                  mem_we;
   logic [LEN_W-1:0]      len_dec;
   logic [CMP_W-1:0]      pad_diff;

   ita_div_unit #(
      .VALUE_BITS(VALUE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .operand  (div_operand),
      .stat     (div_stat),
      .quotient (div_quotient)
   );

   // Decode the request; radix code three falls to hex
   always_comb begin
      case (req_ch.mode)
         RADIX_DEC: radix_sel = RADIX_DEC;
         RADIX_OCT: radix_sel = RADIX_OCT;
         default:   radix_sel = RADIX_HEX;
      endcase
   end

   assign raw_value = req_ch.value[VALUE_BITS-1:0];
   assign is_neg    = req_ch.signed_value & raw_value[VALUE_BITS-1];
   // the most negative value negates to itself, which reads right as unsigned
   assign magnitude = is_neg ? (~raw_value + VALUE_BITS'(1)) : raw_value;
   assign width_sat = (req_ch.pad_width > PAD_BITS'(MAX_PAD)) ?
                      PAD_BITS'(MAX_PAD) : req_ch.pad_width;

   // hold off requests while reset is applied
   assign req_ch.ready = (state_ff == ST_IDLE) & ~reset;
   assign req_fire     = req_ch.valid & req_ch.ready;
   assign out_free     = ~rsp_valid_ff | rsp_ch.ready;
   assign len_dec      = len_ff - LEN_W'(1);
   assign pad_diff     = CMP_W'(width_ff) - CMP_W'(len_ff);

   always_comb begin
      state_in      = state_ff;
      radix_in      = radix_ff;
      sign_in       = sign_ff;
      prefix_cnt_in = prefix_cnt_ff;
      zpad_in       = zpad_ff;
      width_in      = width_ff;
      pad_cnt_in    = pad_cnt_ff;
      len_in        = len_ff;
      rd_ptr_in     = rd_ptr_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ch.ready;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = rsp_last_ff;
      div_ctrl.start = 1'b0;
      div_ctrl.radix = radix_ff;
      div_operand    = div_quotient;
      mem_we         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            div_ctrl.radix = radix_sel;
            div_operand    = magnitude;
            if (req_fire) begin
               radix_in       = radix_sel;
               sign_in        = is_neg;
               prefix_cnt_in  = (req_ch.show_prefix && radix_sel == RADIX_HEX) ? 2'd2 : 2'd0;
               zpad_in        = req_ch.zero_pad;
               width_in       = width_sat;
               len_in         = '0;
               div_ctrl.start = 1'b1;
               state_in       = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // store each digit, least significant first; drop digits past the store
            if (div_stat.done) begin
               if (len_ff < LEN_W'(DIGIT_STORE)) begin
                  mem_we = 1'b1;
                  len_in = len_ff + LEN_W'(1);
               end
               if (div_quotient == '0) begin
                  state_in = ST_SETTLE;
               end else begin
                  div_ctrl.start = 1'b1;
               end
            end
         end
         ST_SETTLE: begin
            // padding count and first read address, once the digit count is final
            pad_cnt_in = (CMP_W'(width_ff) > CMP_W'(len_ff)) ? pad_diff[PAD_BITS-1:0] : '0;
            rd_ptr_in  = len_dec[AW-1:0];
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b0;
               if (sign_ff) begin
                  rsp_char_in = CHAR_MINUS;
                  sign_in     = 1'b0;
               end else if (prefix_cnt_ff != 2'd0) begin
                  rsp_char_in   = (prefix_cnt_ff == 2'd2) ? CHAR_ZERO : CHAR_X;
                  prefix_cnt_in = prefix_cnt_ff - 2'd1;
               end else if (pad_cnt_ff != '0) begin
                  rsp_char_in = zpad_ff ? CHAR_ZERO : CHAR_SPACE;
                  pad_cnt_in  = pad_cnt_ff - PAD_BITS'(1);
               end else begin
                  // digits go out most significant first
                  rsp_char_in = digit_char(rd_data_ff);
                  if (rd_ptr_ff == '0) begin
                     rsp_last_in = 1'b1;
                     state_in    = ST_IDLE;
                  end else begin
                     rd_ptr_in = rd_ptr_ff - AW'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      radix_ff      <= radix_in;
      sign_ff       <= sign_in;
      prefix_cnt_ff <= prefix_cnt_in;
      zpad_ff       <= zpad_in;
      width_ff      <= width_in;
      pad_cnt_ff    <= pad_cnt_in;
      len_ff        <= len_in;
      rd_ptr_ff     <= rd_ptr_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Digit store; the read follows the next pointer so rd_data_ff matches rd_ptr_ff
   always_ff @(posedge clock) begin
      if (mem_we) begin
         digit_mem[len_ff[AW-1:0]] <= div_stat.digit;
      end
      rd_data_ff <= digit_mem[rd_ptr_in];
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.character = rsp_char_ff;
   assign rsp_ch.last      = rsp_last_ff;

   // Emission reads only digits that were stored for this transaction
   a_emit_ptr: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> (len_ff != '0 && LEN_W'(rd_ptr_ff) < len_ff))
      else $error("digit pointer outside stored digits");

   // The divider finishes only while the sequencer waits on it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIVIDE)
      else $error("divider done outside divide phase");

   // A character that is not the final one leaves the block mid-transaction
   a_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.last) |-> state_ff == ST_EMIT)
      else $error("non-final character without pending emission");

endmodule

`default_nettype wire
